// File: hdl/savi_pkg.sv
// Shared types, codes and the pair-sequence program of the artificial viscosity block.
package savi_pkg;

   localparam int IDX_W = 10;
   localparam int PC_W = 5;
   localparam int PROG_LEN = 29;
   localparam int DIV_STEPS = 48;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_PAIR = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_SWEEP = 1'b1;

   localparam logic [1:0] CSR_ALPHA = 2'd0;
   localparam logic [1:0] CSR_BETA = 2'd1;
   localparam logic [1:0] CSR_ETA = 2'd2;
   localparam logic [1:0] CSR_COUNT = 2'd3;

   localparam logic [20:0] ALPHA_RESET = 21'd65536;
   localparam logic [20:0] BETA_RESET = 21'd65536;
   localparam logic [16:0] ETA_RESET = 17'd6554;

   localparam logic [5:0] OP_NONE = 6'd0;
   localparam logic [5:0] OP_CLEAR = 6'd1;
   localparam logic [5:0] OP_LOAD = 6'd2;
   localparam logic [5:0] OP_RD_PI = 6'd3;
   localparam logic [5:0] OP_RD_PJ = 6'd4;
   localparam logic [5:0] OP_LAT_PJ = 6'd5;
   localparam logic [5:0] OP_DIFF = 6'd6;
   localparam logic [5:0] OP_VR = 6'd7;
   localparam logic [5:0] OP_RR = 6'd8;
   localparam logic [5:0] OP_MH2 = 6'd9;
   localparam logic [5:0] OP_ETA2 = 6'd10;
   localparam logic [5:0] OP_DENM = 6'd11;
   localparam logic [5:0] OP_DEN = 6'd12;
   localparam logic [5:0] OP_NUM = 6'd13;
   localparam logic [5:0] OP_DIV1 = 6'd14;
   localparam logic [5:0] OP_MU = 6'd15;
   localparam logic [5:0] OP_T1 = 6'd16;
   localparam logic [5:0] OP_T2 = 6'd17;
   localparam logic [5:0] OP_T = 6'd18;
   localparam logic [5:0] OP_PN = 6'd19;
   localparam logic [5:0] OP_DIV2 = 6'd20;
   localparam logic [5:0] OP_PIV = 6'd21;
   localparam logic [5:0] OP_HH = 6'd22;
   localparam logic [5:0] OP_DAI = 6'd23;
   localparam logic [5:0] OP_DAJ = 6'd24;
   localparam logic [5:0] OP_DEI = 6'd25;
   localparam logic [5:0] OP_DEJ = 6'd26;
   localparam logic [5:0] OP_ACC_RDI = 6'd27;
   localparam logic [5:0] OP_ACC_CALCI = 6'd28;
   localparam logic [5:0] OP_ACC_CALCJ = 6'd29;
   localparam logic [5:0] OP_ACC_WRI = 6'd30;
   localparam logic [5:0] OP_ACC_WRJ = 6'd31;
   localparam logic [5:0] OP_PAIR_END = 6'd32;
   localparam logic [5:0] OP_RO_RD = 6'd33;
   localparam logic [5:0] OP_RO_OUT = 6'd34;
   localparam logic [5:0] OP_RO_BAD = 6'd35;

   typedef struct packed {
      logic [1:0] kind;
      logic [IDX_W-1:0] pi;
      logic [IDX_W-1:0] pj;
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic [30:0] hsml;
      logic [30:0] speed;
      logic [30:0] rho;
      logic [30:0] mass;
      logic signed [31:0] grad;
      logic last;
   } item_type;

   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic [30:0] hsml;
      logic [30:0] speed;
      logic [30:0] rho;
      logic [30:0] mass;
   } part_type;

   typedef struct packed {
      logic sat;
      logic signed [31:0] energy;
      logic signed [31:0] accel;
   } acc_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic clip;
   } div_res_type;

   typedef struct packed {
      logic latch;
      logic [5:0] op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic valid_i;
      logic valid_j;
      logic last;
      logic approach;
      logic div_busy;
      logic clear_done;
   } stat_type;

   function automatic logic [5:0] prog_op(input logic [PC_W-1:0] pc);
      logic [5:0] op;
      case (pc)
         5'd0: op = OP_RD_PI;
         5'd1: op = OP_RD_PJ;
         5'd2: op = OP_LAT_PJ;
         5'd3: op = OP_DIFF;
         5'd4: op = OP_VR;
         5'd5: op = OP_RR;
         5'd6: op = OP_MH2;
         5'd7: op = OP_ETA2;
         5'd8: op = OP_DENM;
         5'd9: op = OP_DEN;
         5'd10: op = OP_NUM;
         5'd11: op = OP_DIV1;
         5'd12: op = OP_MU;
         5'd13: op = OP_T1;
         5'd14: op = OP_T2;
         5'd15: op = OP_T;
         5'd16: op = OP_PN;
         5'd17: op = OP_DIV2;
         5'd18: op = OP_PIV;
         5'd19: op = OP_HH;
         5'd20: op = OP_DAI;
         5'd21: op = OP_DAJ;
         5'd22: op = OP_DEI;
         5'd23: op = OP_DEJ;
         5'd24: op = OP_ACC_RDI;
         5'd25: op = OP_ACC_CALCI;
         5'd26: op = OP_ACC_CALCJ;
         5'd27: op = OP_ACC_WRI;
         5'd28: op = OP_ACC_WRJ;
         default: op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

// File: hdl/savi_div.sv
// Iterative restoring divider for Q16.16 quotients with saturation.
module savi_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [31:0] num,
   input  logic [31:0] den,
   output logic busy,
   output savi_pkg::div_res_type res
);

   logic [47:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic neg_ff, neg_in;
   logic [32:0] nx, mag, rem_sh, diff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      nx = {num[31], num};
      mag = num[31] ? (~nx + 33'd1) : nx;
      rem_sh = {rem_ff[31:0], quo_ff[47]};
      diff = rem_sh - {1'b0, den_ff};
      if (start) begin
         neg_in = num[31];
         if (den == 32'd0) begin
            quo_in = (num == 32'sd0) ? 48'd0 : {48{1'b1}};
            busy_in = 1'b0;
         end else begin
            quo_in = {mag[31:0], 16'd0};
            rem_in = 33'd0;
            den_in = den;
            cnt_in = 6'd0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff;
         end else begin
            rem_in = rem_sh;
         end
         quo_in = {quo_ff[46:0], !diff[32]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(savi_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (!neg_ff) begin
         res.clip = |quo_ff[47:31];
         res.val = res.clip ? 32'sh7FFF_FFFF : $signed(quo_ff[31:0]);
      end else begin
         res.clip = quo_ff > 48'h0000_8000_0000;
         res.val = res.clip ? 32'sh8000_0000 : $signed(-quo_ff[31:0]);
      end
   end

   assign busy = busy_ff;

endmodule

// File: hdl/savi_dp.sv
// Datapath: particle and accumulator memories, shared multiplier, divider and result register.
module savi_dp #(
   parameter int MAX_PARTICLES = 1024
) (
   input  logic clock,
   input  logic reset,
   input  savi_pkg::cmd_type cmd,
   output savi_pkg::stat_type stat,
   input  savi_pkg::item_type req_item,
   input  logic csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [20:0] csr_wdata,
   output logic rsp_kind,
   output logic [9:0] rsp_index,
   output logic signed [31:0] rsp_accel,
   output logic signed [31:0] rsp_energy,
   output logic [1:0] rsp_status
);

   localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
   localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

   function automatic logic [32:0] sat_q(input logic signed [49:0] v);
      logic [32:0] r;
      if (v > SAT_HI) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < SAT_LO) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   savi_pkg::item_type item_ff, item_in;
   logic [20:0] alpha_ff, beta_ff;
   logic [16:0] eta_ff;
   logic [10:0] count_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0] sweep_ff, sweep_in;
   logic clip_ff, clip_in;

   savi_pkg::part_type pmem [MAX_PARTICLES];
   savi_pkg::acc_type amem [MAX_PARTICLES];
   savi_pkg::part_type prd_ff, pa_ff, pa_in, pb_ff, pb_in;
   savi_pkg::acc_type ard_ff, new_i_ff, new_i_in, new_j_ff, new_j_in, abase, awdata;

   logic signed [31:0] dv_ff, dx_ff, mh_ff, mc_ff, mrho_ff, vr_ff, rr_ff, mh2_ff, tmp_ff;
   logic signed [31:0] den_ff, num_ff, mu_ff, t_ff, pn_ff, piv_ff, hh_ff;
   logic signed [31:0] dai_ff, daj_ff, dei_ff, dej_ff;
   logic signed [31:0] dv_in, dx_in, mh_in, mc_in, mrho_in, vr_in, rr_in, mh2_in, tmp_in;
   logic signed [31:0] den_in, num_in, mu_in, t_in, pn_in, piv_in, hh_in;
   logic signed [31:0] dai_in, daj_in, dei_in, dej_in;

   logic rsp_kind_ff, rsp_kind_in;
   logic [9:0] rsp_index_ff, rsp_index_in;
   logic signed [31:0] rsp_accel_ff, rsp_accel_in, rsp_energy_ff, rsp_energy_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic [AW-1:0] ai, aj, araddr, awaddr, praddr;
   logic pwr, prd, awr, ard;
   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic signed [49:0] msh;
   logic [32:0] mres, sa, sb;
   logic [31:0] hsum, csum, rsum;
   logic [1:0] st_next;
   logic div_start, div_busy, pair_ok;
   logic signed [31:0] div_num;
   logic [31:0] div_den;
   savi_pkg::div_res_type div_res;

   assign ai = AW'(item_ff.pi);
   assign aj = AW'(item_ff.pj);
   assign pair_ok = stat.valid_i && stat.valid_j;

   always_comb begin
      stat.kind = item_ff.kind;
      stat.valid_i = ({1'b0, item_ff.pi} < count_ff) && (32'(item_ff.pi) < 32'(MAX_PARTICLES));
      stat.valid_j = ({1'b0, item_ff.pj} < count_ff) && (32'(item_ff.pj) < 32'(MAX_PARTICLES));
      stat.last = item_ff.last;
      stat.approach = (dv_ff != 32'sd0) && (dx_ff != 32'sd0) && (dv_ff[31] != dx_ff[31]);
      stat.div_busy = div_busy;
      stat.clear_done = clr_ff == AW'(MAX_PARTICLES - 1);
   end

   always_comb begin
      case (cmd.op)
         savi_pkg::OP_VR: begin ma = {dv_ff[31], dv_ff}; mb = {dx_ff[31], dx_ff}; end
         savi_pkg::OP_RR: begin ma = {dx_ff[31], dx_ff}; mb = {dx_ff[31], dx_ff}; end
         savi_pkg::OP_MH2: begin ma = {mh_ff[31], mh_ff}; mb = {mh_ff[31], mh_ff}; end
         savi_pkg::OP_ETA2: begin ma = {16'd0, eta_ff}; mb = {16'd0, eta_ff}; end
         savi_pkg::OP_DENM: begin ma = {mh2_ff[31], mh2_ff}; mb = {tmp_ff[31], tmp_ff}; end
         savi_pkg::OP_NUM: begin ma = {mh_ff[31], mh_ff}; mb = {vr_ff[31], vr_ff}; end
         savi_pkg::OP_T1: begin ma = {12'd0, beta_ff}; mb = {mu_ff[31], mu_ff}; end
         savi_pkg::OP_T2: begin ma = {12'd0, alpha_ff}; mb = {mc_ff[31], mc_ff}; end
         savi_pkg::OP_PN: begin ma = {t_ff[31], t_ff}; mb = {mu_ff[31], mu_ff}; end
         savi_pkg::OP_HH: begin ma = -{piv_ff[31], piv_ff}; mb = {item_ff.grad[31], item_ff.grad}; end
         savi_pkg::OP_DAI: begin ma = {2'd0, pb_ff.mass}; mb = {hh_ff[31], hh_ff}; end
         savi_pkg::OP_DAJ: begin ma = {2'd0, pa_ff.mass}; mb = {hh_ff[31], hh_ff}; end
         savi_pkg::OP_DEI: begin ma = {dai_ff[31], dai_ff}; mb = {dv_ff[31], dv_ff}; end
         savi_pkg::OP_DEJ: begin ma = {daj_ff[31], daj_ff}; mb = {dv_ff[31], dv_ff}; end
         default: begin ma = 33'sd0; mb = 33'sd0; end
      endcase
      prod = ma * mb;
      msh = prod[65:16];
      mres = sat_q(msh);
   end

   assign div_start = (cmd.op == savi_pkg::OP_DIV1) || (cmd.op == savi_pkg::OP_DIV2);
   assign div_num = (cmd.op == savi_pkg::OP_DIV2) ? pn_ff : num_ff;
   assign div_den = (cmd.op == savi_pkg::OP_DIV2) ? mrho_ff : den_ff;

   savi_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .busy(div_busy),
      .res(div_res)
   );

   always_comb begin
      item_in = cmd.latch ? req_item : item_ff;
      clr_in = clr_ff;
      sweep_in = sweep_ff;
      clip_in = clip_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      new_i_in = new_i_ff;
      new_j_in = new_j_ff;
      dv_in = dv_ff; dx_in = dx_ff; mh_in = mh_ff; mc_in = mc_ff; mrho_in = mrho_ff;
      vr_in = vr_ff; rr_in = rr_ff; mh2_in = mh2_ff; tmp_in = tmp_ff; den_in = den_ff;
      num_in = num_ff; mu_in = mu_ff; t_in = t_ff; pn_in = pn_ff; piv_in = piv_ff;
      hh_in = hh_ff; dai_in = dai_ff; daj_in = daj_ff; dei_in = dei_ff; dej_in = dej_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      rsp_accel_in = rsp_accel_ff;
      rsp_energy_in = rsp_energy_ff;
      rsp_status_in = rsp_status_ff;
      pwr = 1'b0;
      prd = 1'b0;
      praddr = ai;
      awr = 1'b0;
      ard = 1'b0;
      araddr = ai;
      awaddr = ai;
      awdata = '0;
      abase = ((item_ff.pi == item_ff.pj) && (cmd.op == savi_pkg::OP_ACC_CALCJ)) ?
              new_i_ff : ard_ff;
      hsum = 32'(pa_ff.hsml) + 32'(pb_ff.hsml);
      csum = 32'(pa_ff.speed) + 32'(pb_ff.speed);
      rsum = 32'(pa_ff.rho) + 32'(pb_ff.rho);
      sa = sat_q(50'(pa_ff.vel) - 50'(pb_ff.vel));
      sb = sat_q(50'(pa_ff.pos) - 50'(pb_ff.pos));
      st_next = (!pair_ok && (sweep_ff == savi_pkg::ST_OK)) ? savi_pkg::ST_RANGE : sweep_ff;
      case (cmd.op)
         savi_pkg::OP_CLEAR: begin
            awr = 1'b1;
            awaddr = clr_ff;
            clr_in = clr_ff + AW'(1);
         end
         savi_pkg::OP_LOAD: pwr = 1'b1;
         savi_pkg::OP_RD_PI: prd = 1'b1;
         savi_pkg::OP_RD_PJ: begin
            prd = 1'b1;
            praddr = aj;
            pa_in = prd_ff;
         end
         savi_pkg::OP_LAT_PJ: pb_in = prd_ff;
         savi_pkg::OP_DIFF: begin
            dv_in = $signed(sa[31:0]);
            dx_in = $signed(sb[31:0]);
            clip_in = sa[32] | sb[32];
            mh_in = {1'b0, hsum[31:1]};
            mc_in = {1'b0, csum[31:1]};
            mrho_in = {1'b0, rsum[31:1]};
         end
         savi_pkg::OP_VR: begin vr_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_RR: begin rr_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_MH2: begin mh2_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_ETA2: tmp_in = $signed(mres[31:0]);
         savi_pkg::OP_DENM: begin tmp_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_DEN: begin
            sa = sat_q(50'(rr_ff) + 50'(tmp_ff));
            den_in = $signed(sa[31:0]);
            clip_in = clip_ff | sa[32];
         end
         savi_pkg::OP_NUM: begin num_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_MU: begin mu_in = div_res.val; clip_in = clip_ff | div_res.clip; end
         savi_pkg::OP_T1: begin tmp_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_T2: begin t_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_T: begin
            sa = sat_q(50'(tmp_ff) - 50'(t_ff));
            t_in = $signed(sa[31:0]);
            clip_in = clip_ff | sa[32];
         end
         savi_pkg::OP_PN: begin pn_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_PIV: begin piv_in = div_res.val; clip_in = clip_ff | div_res.clip; end
         savi_pkg::OP_HH: begin hh_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_DAI: begin dai_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_DAJ: begin daj_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_DEI: begin dei_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_DEJ: begin dej_in = $signed(mres[31:0]); clip_in = clip_ff | mres[32]; end
         savi_pkg::OP_ACC_RDI: ard = 1'b1;
         savi_pkg::OP_ACC_CALCI: begin
            ard = 1'b1;
            araddr = aj;
            sa = sat_q(50'(abase.accel) + 50'(dai_ff));
            sb = sat_q(50'(abase.energy) - 50'(dei_ff));
            new_i_in = {abase.sat, sb[31:0], sa[31:0]};
            clip_in = clip_ff | sa[32] | sb[32];
         end
         savi_pkg::OP_ACC_CALCJ: begin
            sa = sat_q(50'(abase.accel) - 50'(daj_ff));
            sb = sat_q(50'(abase.energy) - 50'(dej_ff));
            new_j_in = {abase.sat, sb[31:0], sa[31:0]};
            clip_in = clip_ff | sa[32] | sb[32];
         end
         savi_pkg::OP_ACC_WRI: begin
            awr = 1'b1;
            awdata = {new_i_ff.sat | clip_ff, new_i_ff.energy, new_i_ff.accel};
         end
         savi_pkg::OP_ACC_WRJ: begin
            awr = 1'b1;
            awaddr = aj;
            awdata = {new_j_ff.sat | clip_ff, new_j_ff.energy, new_j_ff.accel};
            if (clip_ff) begin
               sweep_in = savi_pkg::ST_SAT;
            end
         end
         savi_pkg::OP_PAIR_END: begin
            if (item_ff.last) begin
               rsp_kind_in = savi_pkg::KIND_SWEEP;
               rsp_index_in = 10'd0;
               rsp_accel_in = 32'sd0;
               rsp_energy_in = 32'sd0;
               rsp_status_in = st_next;
               sweep_in = savi_pkg::ST_OK;
            end else begin
               sweep_in = st_next;
            end
         end
         savi_pkg::OP_RO_RD: ard = 1'b1;
         savi_pkg::OP_RO_OUT: begin
            awr = 1'b1;
            rsp_kind_in = savi_pkg::KIND_READ;
            rsp_index_in = item_ff.pi;
            rsp_accel_in = ard_ff.accel;
            rsp_energy_in = {ard_ff.energy[31], ard_ff.energy[31:1]};
            rsp_status_in = ard_ff.sat ? savi_pkg::ST_SAT : savi_pkg::ST_OK;
         end
         savi_pkg::OP_RO_BAD: begin
            rsp_kind_in = savi_pkg::KIND_READ;
            rsp_index_in = item_ff.pi;
            rsp_accel_in = 32'sd0;
            rsp_energy_in = 32'sd0;
            rsp_status_in = savi_pkg::ST_RANGE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pwr) begin
         pmem[ai] <= {item_ff.pos, item_ff.vel, item_ff.hsml, item_ff.speed,
                      item_ff.rho, item_ff.mass};
      end
      if (prd) begin
         prd_ff <= pmem[praddr];
      end
   end

   always_ff @(posedge clock) begin
      if (awr) begin
         amem[awaddr] <= awdata;
      end
      if (ard) begin
         ard_ff <= amem[araddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= savi_pkg::ALPHA_RESET;
         beta_ff <= savi_pkg::BETA_RESET;
         eta_ff <= savi_pkg::ETA_RESET;
         count_ff <= 11'd0;
         clr_ff <= '0;
         sweep_ff <= savi_pkg::ST_OK;
      end else begin
         clr_ff <= clr_in;
         sweep_ff <= sweep_in;
         if (csr_wr_en) begin
            case (csr_index)
               savi_pkg::CSR_ALPHA: alpha_ff <= csr_wdata;
               savi_pkg::CSR_BETA: beta_ff <= csr_wdata;
               savi_pkg::CSR_ETA: eta_ff <= csr_wdata[16:0];
               savi_pkg::CSR_COUNT: count_ff <= csr_wdata[10:0];
               default: begin
               end
            endcase
         end
      end
      item_ff <= item_in;
      clip_ff <= clip_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      new_i_ff <= new_i_in;
      new_j_ff <= new_j_in;
      dv_ff <= dv_in; dx_ff <= dx_in; mh_ff <= mh_in; mc_ff <= mc_in; mrho_ff <= mrho_in;
      vr_ff <= vr_in; rr_ff <= rr_in; mh2_ff <= mh2_in; tmp_ff <= tmp_in; den_ff <= den_in;
      num_ff <= num_in; mu_ff <= mu_in; t_ff <= t_in; pn_ff <= pn_in; piv_ff <= piv_in;
      hh_ff <= hh_in; dai_ff <= dai_in; daj_ff <= daj_in; dei_ff <= dei_in; dej_ff <= dej_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_accel_ff <= rsp_accel_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_kind = rsp_kind_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_accel = rsp_accel_ff;
   assign rsp_energy = rsp_energy_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: hdl/savi_ctrl.sv
// Controller: request decode, clearing pass and the pair-sequence program.
module savi_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  savi_pkg::stat_type stat,
   output savi_pkg::cmd_type cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_PAIR = 4'd3;
   localparam logic [3:0] S_DIVW = 4'd4;
   localparam logic [3:0] S_END = 4'd5;
   localparam logic [3:0] S_RO_RD = 4'd6;
   localparam logic [3:0] S_RO_OUT = 4'd7;
   localparam logic [3:0] S_RESP = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [savi_pkg::PC_W-1:0] pc_ff, pc_in;
   logic [5:0] prog;

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      cmd.latch = 1'b0;
      cmd.op = savi_pkg::OP_NONE;
      prog = savi_pkg::prog_op(pc_ff);
      req_tready = state_ff == S_IDLE;
      rsp_tvalid = state_ff == S_RESP;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = savi_pkg::OP_CLEAR;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.kind)
               savi_pkg::REQ_LOAD: begin
                  cmd.op = stat.valid_i ? savi_pkg::OP_LOAD : savi_pkg::OP_NONE;
                  state_in = S_IDLE;
               end
               savi_pkg::REQ_PAIR: begin
                  pc_in = '0;
                  state_in = (stat.valid_i && stat.valid_j) ? S_PAIR : S_END;
               end
               savi_pkg::REQ_READ: begin
                  if (stat.valid_i) begin
                     state_in = S_RO_RD;
                  end else begin
                     cmd.op = savi_pkg::OP_RO_BAD;
                     state_in = S_RESP;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PAIR: begin
            if (prog == savi_pkg::OP_VR && !stat.approach) begin
               state_in = S_END;
            end else begin
               cmd.op = prog;
               pc_in = pc_ff + 1'b1;
               if (prog == savi_pkg::OP_DIV1 || prog == savi_pkg::OP_DIV2) begin
                  state_in = S_DIVW;
               end else if (pc_ff == savi_pkg::PC_W'(savi_pkg::PROG_LEN - 1)) begin
                  state_in = S_END;
               end
            end
         end
         S_DIVW: begin
            if (!stat.div_busy) begin
               state_in = S_PAIR;
            end
         end
         S_END: begin
            cmd.op = savi_pkg::OP_PAIR_END;
            state_in = stat.last ? S_RESP : S_IDLE;
         end
         S_RO_RD: begin
            cmd.op = savi_pkg::OP_RO_RD;
            state_in = S_RO_OUT;
         end
         S_RO_OUT: begin
            cmd.op = savi_pkg::OP_RO_OUT;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pc_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
      end
   end

endmodule

// File: hdl/sph_artificial_viscosity.sv
// Top level of the one-dimensional SPH artificial viscosity accelerator.
// After reset the block clears all MAX_PARTICLES entries of its accumulator memory, one
// particle a cycle, and takes no request until that pass is done. It then handles one
// request at a time: a load, a read-out followed by the result handshake, or a pair of
// approaching particles, which runs the 29-step program on the shared multiplier with two
// bit-serial divisions; a pair that does not approach skips the rest of that program.
module sph_artificial_viscosity #(
   parameter int MAX_PARTICLES = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // particle_index, partner_index, position, velocity, smoothing_length,
   // sound_speed, density, particle_mass, kernel_gradient
   input  logic [239:0] req_tdata,
   // req_type
   input  logic [1:0] req_tuser,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_index, accel_increment, energy_increment, status
   output logic [79:0] rsp_tdata,
   // result_kind
   output logic rsp_tuser,
   input  logic csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [20:0] csr_wdata
);

   savi_pkg::item_type req_item;
   savi_pkg::cmd_type cmd;
   savi_pkg::stat_type stat;
   logic [9:0] rsp_index;
   logic signed [31:0] rsp_accel, rsp_energy;
   logic [1:0] rsp_status;

   always_comb begin
      req_item.kind = req_tuser;
      req_item.pi = req_tdata[9:0];
      req_item.pj = req_tdata[19:10];
      req_item.pos = $signed(req_tdata[51:20]);
      req_item.vel = $signed(req_tdata[83:52]);
      req_item.hsml = req_tdata[114:84];
      req_item.speed = req_tdata[145:115];
      req_item.rho = req_tdata[176:146];
      req_item.mass = req_tdata[207:177];
      req_item.grad = $signed(req_tdata[239:208]);
      req_item.last = req_tlast;
   end

   savi_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .stat(stat),
      .cmd(cmd)
   );

   savi_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_item(req_item),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_kind(rsp_tuser),
      .rsp_index(rsp_index),
      .rsp_accel(rsp_accel),
      .rsp_energy(rsp_energy),
      .rsp_status(rsp_status)
   );

   assign rsp_tdata = {4'd0, rsp_status, rsp_energy, rsp_accel, rsp_index};

endmodule

// File: tb/sph_artificial_viscosity_tb.sv
// Self-checking testbench for the SPH artificial viscosity block: a stream driver, a monitor
// and a fixed-point predictor of the particle accumulators.
`timescale 1ns / 100ps

module sph_artificial_viscosity_tb;

   localparam int NPART = 1024;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE = 300;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam logic [1:0] REQ_SPARE = 2'd3;

   typedef struct {
      logic kind;
      logic [9:0] idx;
      logic [31:0] accel;
      logic [31:0] energy;
      logic [1:0] status;
   } rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [239:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [20:0] csr_wdata = '0;

   sph_artificial_viscosity #(.MAX_PARTICLES(NPART)) dut (.*);

   savi_pkg::item_type pending[$];
   rsp_type expected_rsp[$];
   savi_pkg::item_type cur;
   logic req_took = 1'b0;
   int src_idle = 0;
   int rcv_stall = 0;
   int errors = 0;
   int quiet_cycles = 0;

   longint m_pos[NPART], m_vel[NPART], m_hsml[NPART], m_speed[NPART];
   longint m_rho[NPART], m_mass[NPART], m_acc[NPART], m_eng[NPART];
   bit m_sat[NPART];
   logic [1:0] sweep_st = savi_pkg::ST_OK;
   longint m_alpha = 65536, m_beta = 65536, m_eta = 6554, m_count = 0;
   bit clipped;
   int usable[$];

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint clip32(longint v);
      if (v > QMAX) begin
         clipped = 1'b1;
         return QMAX;
      end
      if (v < QMIN) begin
         clipped = 1'b1;
         return QMIN;
      end
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return clip32((a * b) >>> 16);
   endfunction

   function automatic longint qdiv(longint n, longint d);
      if (d == 0) begin
         if (n == 0) return 0;
         clipped = 1'b1;
         return (n > 0) ? QMAX : QMIN;
      end
      return clip32((n * 65536) / d);
   endfunction

   function automatic bit idx_ok(longint idx);
      return (idx < m_count) && (idx < NPART);
   endfunction

   task automatic pair_update(int i, int j, longint grad);
      longint dv, dx, vr, rr, mh, mh2, eta2, den, num, mu, mc, mrho, t, pn, piv, hh;
      longint dai, daj, dei, dej;
      clipped = 1'b0;
      dv = clip32(m_vel[i] - m_vel[j]);
      dx = clip32(m_pos[i] - m_pos[j]);
      if (dv * dx >= 0) return;
      vr = qmul(dv, dx);
      rr = qmul(dx, dx);
      mh = clip32((m_hsml[i] + m_hsml[j]) >>> 1);
      mh2 = qmul(mh, mh);
      eta2 = (m_eta * m_eta) >>> 16;
      den = clip32(rr + qmul(mh2, eta2));
      num = qmul(mh, vr);
      mu = qdiv(num, den);
      mc = clip32((m_speed[i] + m_speed[j]) >>> 1);
      mrho = clip32((m_rho[i] + m_rho[j]) >>> 1);
      t = clip32(qmul(m_beta, mu) - qmul(m_alpha, mc));
      pn = qmul(t, mu);
      piv = qdiv(pn, mrho);
      hh = qmul(-piv, grad);
      dai = qmul(m_mass[j], hh);
      daj = qmul(m_mass[i], hh);
      dei = qmul(dai, dv);
      dej = qmul(daj, dv);
      m_acc[i] = clip32(m_acc[i] + dai);
      m_eng[i] = clip32(m_eng[i] - dei);
      m_acc[j] = clip32(m_acc[j] - daj);
      m_eng[j] = clip32(m_eng[j] - dej);
      if (clipped) begin
         m_sat[i] = 1'b1;
         m_sat[j] = 1'b1;
         sweep_st = savi_pkg::ST_SAT;
      end
   endtask

   task automatic predict_request(savi_pkg::item_type it);
      rsp_type r;
      case (it.kind)
         savi_pkg::REQ_LOAD: begin
            if (idx_ok(it.pi)) begin
               m_pos[it.pi] = longint'(it.pos);
               m_vel[it.pi] = longint'(it.vel);
               m_hsml[it.pi] = longint'({1'b0, it.hsml});
               m_speed[it.pi] = longint'({1'b0, it.speed});
               m_rho[it.pi] = longint'({1'b0, it.rho});
               m_mass[it.pi] = longint'({1'b0, it.mass});
            end
         end
         savi_pkg::REQ_PAIR: begin
            if (idx_ok(it.pi) && idx_ok(it.pj))
               pair_update(int'(it.pi), int'(it.pj), longint'(it.grad));
            else if (sweep_st == savi_pkg::ST_OK)
               sweep_st = savi_pkg::ST_RANGE;
            if (it.last) begin
               r = '{savi_pkg::KIND_SWEEP, 10'd0, 32'd0, 32'd0, sweep_st};
               expected_rsp.push_back(r);
               sweep_st = savi_pkg::ST_OK;
            end
         end
         savi_pkg::REQ_READ: begin
            if (!idx_ok(it.pi)) begin
               r = '{savi_pkg::KIND_READ, it.pi, 32'd0, 32'd0, savi_pkg::ST_RANGE};
            end else begin
               r = '{savi_pkg::KIND_READ, it.pi, m_acc[it.pi][31:0],
                     32'(m_eng[it.pi] >>> 1),
                     m_sat[it.pi] ? savi_pkg::ST_SAT : savi_pkg::ST_OK};
               m_acc[it.pi] = 0;
               m_eng[it.pi] = 0;
               m_sat[it.pi] = 1'b0;
            end
            expected_rsp.push_back(r);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) predict_request(cur);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                     $realtime, rsp_tuser, rsp_tdata);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_tuser !== e.kind || rsp_tdata[9:0] !== e.idx
                || rsp_tdata[41:10] !== e.accel || rsp_tdata[73:42] !== e.energy
                || rsp_tdata[75:74] !== e.status) begin
               errors++;
               $display("%0t: mismatch, expected kind %0d idx %0d acc %h eng %h st %0d",
                        $realtime, e.kind, e.idx, e.accel, e.energy, e.status);
               $display("%0t:           actual kind %0d idx %0d acc %h eng %h st %0d",
                        $realtime, rsp_tuser, rsp_tdata[9:0], rsp_tdata[41:10],
                        rsp_tdata[73:42], rsp_tdata[75:74]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sph_artificial_viscosity_tb: errors");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_took) begin
            if (pending.size() != 0 && $urandom_range(99) >= src_idle) begin
               cur = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {cur.grad, cur.mass, cur.rho, cur.speed, cur.hsml,
                             cur.vel, cur.pos, cur.pj, cur.pi};
               req_tuser <= cur.kind;
               req_tlast <= cur.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rcv_stall);
      end
   end

   function automatic savi_pkg::item_type blank_item(logic [1:0] kind);
      savi_pkg::item_type it;
      it.kind = kind;
      it.pi = 10'($urandom);
      it.pj = 10'($urandom);
      it.pos = $urandom;
      it.vel = $urandom;
      it.hsml = 31'($urandom);
      it.speed = 31'($urandom);
      it.rho = 31'($urandom);
      it.mass = 31'($urandom);
      it.grad = $urandom;
      it.last = 1'($urandom);
      return it;
   endfunction

   // Moderate values keep most pairs out of saturation; some loads use the full range.
   task automatic push_load(int idx, bit wide);
      savi_pkg::item_type it;
      it = blank_item(savi_pkg::REQ_LOAD);
      it.pi = 10'(idx);
      if (!wide) begin
         it.pos = $urandom_range(0, 20 << 16) - (10 << 16);
         it.vel = $urandom_range(0, 8 << 16) - (4 << 16);
         it.hsml = 31'($urandom_range(1 << 15, 3 << 16));
         it.speed = 31'($urandom_range(1 << 16, 10 << 16));
         it.rho = 31'($urandom_range(1 << 15, 5 << 16));
         it.mass = 31'($urandom_range(1 << 12, 2 << 16));
      end
      pending.push_back(it);
   endtask

   task automatic push_pair(int i, int j, bit last);
      savi_pkg::item_type it;
      it = blank_item(savi_pkg::REQ_PAIR);
      it.pi = 10'(i);
      it.pj = 10'(j);
      it.last = last;
      if ($urandom_range(3) != 0) it.grad = $urandom_range(0, 4 << 16) - (2 << 16);
      pending.push_back(it);
   endtask

   task automatic push_read(int idx);
      savi_pkg::item_type it;
      it = blank_item(savi_pkg::REQ_READ);
      it.pi = 10'(idx);
      pending.push_back(it);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [20:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         savi_pkg::CSR_ALPHA: m_alpha = val;
         savi_pkg::CSR_BETA: m_beta = val;
         savi_pkg::CSR_ETA: m_eta = val[16:0];
         savi_pkg::CSR_COUNT: m_count = val[10:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(int cnt, int a, int b, int e);
      csr_write(savi_pkg::CSR_ALPHA, 21'(a));
      csr_write(savi_pkg::CSR_BETA, 21'(b));
      csr_write(savi_pkg::CSR_ETA, 21'(e));
      csr_write(savi_pkg::CSR_COUNT, 21'(cnt));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(int cnt, int a, int b, int e, int n, int si, int rs);
      int k, r, i, j, bad;
      configure(cnt, a, b, e);
      src_idle = si;
      rcv_stall = rs;
      usable.delete();
      for (k = 0; k < cnt && k < 8; k++) usable.push_back(k);
      for (k = (cnt > 8 ? cnt - 4 : cnt); k < cnt; k++) usable.push_back(k);
      foreach (usable[u]) push_load(usable[u], $urandom_range(9) == 0);
      for (k = 0; k < n; k++) begin
         r = $urandom_range(99);
         bad = (cnt < NPART) ? $urandom_range(cnt, NPART - 1) : 0;
         if (usable.size() == 0 || r >= 85) begin
            case ($urandom_range(3))
               0: pending.push_back(blank_item(REQ_SPARE));
               1: if (cnt < NPART) push_read(bad);
               2: if (cnt < NPART) push_pair(bad, $urandom_range(NPART - 1),
                                             $urandom_range(3) == 0);
               default: if (cnt < NPART) push_load(bad, 1'b1);
            endcase
         end else begin
            i = usable[$urandom_range(usable.size() - 1)];
            j = usable[$urandom_range(usable.size() - 1)];
            if (r < 60) push_pair(i, j, $urandom_range(5) == 0);
            else if (r < 75) push_read(i);
            else push_load(i, $urandom_range(2) == 0);
         end
      end
      if (usable.size() != 0) push_pair(usable[0], usable[usable.size() - 1], 1'b1);
      foreach (usable[u]) push_read(usable[u]);
      drain();
   endtask

   initial begin
      savi_pkg::item_type it;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: extreme operands, divide by zero, out-of-range indices.
      configure(8, savi_pkg::ALPHA_RESET, savi_pkg::BETA_RESET, savi_pkg::ETA_RESET);
      it = blank_item(savi_pkg::REQ_LOAD);
      it.pi = 10'd0;
      it.pos = 32'h7fffffff; it.vel = 32'h80000000;
      it.hsml = 31'h7fffffff; it.speed = 31'h7fffffff;
      it.rho = 31'h7fffffff; it.mass = 31'h7fffffff;
      pending.push_back(it);
      it.pi = 10'd1;
      it.pos = 32'h80000000; it.vel = 32'h7fffffff;
      it.hsml = '0; it.speed = '0; it.rho = '0; it.mass = '0;
      pending.push_back(it);
      it.pi = 10'd2;
      it.pos = 32'd1; it.vel = -32'sd65536; it.hsml = '0; it.rho = '0; it.mass = 31'd65536;
      pending.push_back(it);
      it.pi = 10'd3;
      it.pos = 32'd0; it.vel = 32'd65536; it.hsml = 31'd131072;
      pending.push_back(it);
      for (int k = 4; k < 8; k++) push_load(k, 1'b0);
      push_pair(0, 1, 1'b0);
      push_pair(2, 3, 1'b0);
      push_pair(4, 5, 1'b0);
      push_pair(5, 4, 1'b1);
      push_pair(6, 9, 1'b1);
      push_pair(7, 7, 1'b1);
      for (int k = 0; k < 9; k++) push_read(k);
      push_load(9, 1'b1);
      pending.push_back(blank_item(REQ_SPARE));
      drain();

      random_phase(8, savi_pkg::ALPHA_RESET, savi_pkg::BETA_RESET, 0, 100, 0, 0);
      random_phase(16, 1048576, 0, 65536, 100, 52, 0);
      random_phase(0, 0, 1048576, 6554, 40, 0, 52);
      random_phase(NPART, 32768, 131072, 3277, 100, 17, 17);
      random_phase(12, $urandom_range(1048576), $urandom_range(1048576),
                   $urandom_range(65536), 80, 52, 52);
      random_phase(6, 2097151, 2097151, 131071, 100, 0, 0);

      drain();
      if (errors == 0) begin
         $display("sph_artificial_viscosity_tb: clean");
      end else begin
         $display("sph_artificial_viscosity_tb: errors");
      end
      $finish;
   end

endmodule
